>>> rtl/command_queue_storage_model_top_defines.svh
// assertion macros for the command queue storage block
// used by command_queue_storage_model_top; expects clk and rst_n in scope
`ifndef COMMAND_QUEUE_STORAGE_MODEL_TOP_DEFINES_SVH
`define COMMAND_QUEUE_STORAGE_MODEL_TOP_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define CQSM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define CQSM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define CQSM_ASSERT_IMP(lbl, ante, cons, msg)
`define CQSM_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

>>> rtl/cqsm_pkg.sv
// shared types and constants of the command queue storage block
// no dependencies
package cqsm_pkg;

  localparam int unsigned WORD_W  = 32;
  localparam int unsigned OPC_W   = 2;
  localparam int unsigned KIND_W  = 3;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned CNT_W   = 7;
  localparam int unsigned ENTRY_W = KIND_W + 3 * WORD_W;

  localparam logic [OPC_W-1:0] OP_SUBMIT   = 2'd0;
  localparam logic [OPC_W-1:0] OP_COMPLETE = 2'd1;
  localparam logic [OPC_W-1:0] OP_RESET    = 2'd2;
  localparam logic [OPC_W-1:0] OP_NOP      = 2'd3;

  localparam logic [KIND_W-1:0] KIND_WRITE   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_READ    = 3'd1;
  localparam logic [KIND_W-1:0] KIND_FENCE   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_VISIBLE = 3'd3;

  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_ERR     = 2'd1;
  localparam logic [STAT_W-1:0] ST_TIMEOUT = 2'd2;
  localparam logic [STAT_W-1:0] ST_BAD     = 2'd3;

  localparam logic [4:0] HASH_SHIFT = 5'd5;  // 31 = 32 - 1

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_FETCH,
    S_WRITE,
    S_VRD,
    S_VWR,
    S_RRD,
    S_RACC,
    S_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic step;
    logic acc;
  } walk_ctl_t;

endpackage

>>> rtl/cqsm_ram.sv
// generic single write port ram with registered read
// no dependencies
module cqsm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> rtl/cqsm_walk.sv
// address walker and hash accumulator shared by all range commands
// depends on cqsm_pkg
module cqsm_walk #(
  parameter int unsigned STORE_WORDS = 256
) (
  input  logic                          clk,
  input  cqsm_pkg::walk_ctl_t           ctl,
  input  logic [(STORE_WORDS > 1 ? $clog2(STORE_WORDS) : 1)-1:0] load_addr,
  input  logic [$clog2(STORE_WORDS+1)-1:0] load_count,
  input  logic [cqsm_pkg::WORD_W-1:0]   word,
  output logic [(STORE_WORDS > 1 ? $clog2(STORE_WORDS) : 1)-1:0] addr,
  output logic                          empty,
  output logic [cqsm_pkg::WORD_W-1:0]   hash
);
  localparam int unsigned AW = STORE_WORDS > 1 ? $clog2(STORE_WORDS) : 1;
  localparam int unsigned CW = $clog2(STORE_WORDS + 1);

  logic [AW-1:0]               addr_r;
  logic [CW-1:0]               left_r;
  logic [cqsm_pkg::WORD_W-1:0] hash_r;
  logic [cqsm_pkg::WORD_W-1:0] hash_nxt;

  // hash * 31 + word
  assign hash_nxt = (hash_r << cqsm_pkg::HASH_SHIFT) - hash_r + word;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      addr_r <= load_addr;
      left_r <= load_count;
      hash_r <= '0;
    end else begin
      if (ctl.step) begin
        addr_r <= addr_r + AW'(1);
        left_r <= left_r - CW'(1);
      end
      if (ctl.acc) begin
        hash_r <= hash_nxt;
      end
    end
  end

  assign addr  = addr_r;
  assign empty = (left_r == '0);
  assign hash  = hash_r;
endmodule

>>> rtl/command_queue_storage_model_top.sv
// command queue storage block: pending table, host buffer and device store
// depends on cqsm_pkg, cqsm_ram, cqsm_walk and the assertion macro header
//
// Usage: one input item (opcode with its fields) gives one result item.
// Both channels use valid/stall; an item moves when valid is high and stall
// is low. in_stall is high from acceptance until the result is loaded into
// the output register, so one item is in work at a time.
// Submit, reset, nop and forced or missed completions go from idle to the
// done state and then into the output register. An executed completion
// reads the table entry in the fetch state, then walks its range with the
// shared walker: a write stores one word in each step of the write state;
// write visible and read pass a read state and then a write or accumulate
// state per word, since every word is a registered memory read followed by
// a store write or a hash step. After reset the block clears both stores,
// one word a cycle, with in_stall high; the pending table valid bits and
// counters clear at once. A stalled result holds in the output register
// and the next result waits until it is taken.
`include "command_queue_storage_model_top_defines.svh"
module command_queue_storage_model_top #(
  parameter int unsigned STORE_WORDS = 256,
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_opcode,
  input  logic [2:0]  in_command_type,
  input  logic [31:0] in_start_block,
  input  logic [31:0] in_block_count,
  input  logic [31:0] in_fill_value,
  input  logic [31:0] in_target_id,
  input  logic        in_force_enable,
  input  logic [1:0]  in_forced_status,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_assigned_id,
  output logic        out_fence_flag,
  output logic [31:0] out_fence_number,
  output logic        out_found,
  output logic [1:0]  out_cmd_status,
  output logic [31:0] out_read_hash,
  output logic [6:0]  out_pending_total,
  output logic [6:0]  out_pending_high_mark,
  output logic [6:0]  out_lost_total,
  output logic        out_reset_seen
);
  localparam int unsigned AW = STORE_WORDS > 1 ? $clog2(STORE_WORDS) : 1;
  localparam int unsigned CW = $clog2(STORE_WORDS + 1);
  localparam int unsigned TW = TABLE_DEPTH > 1 ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned W  = cqsm_pkg::WORD_W;
  localparam int unsigned KW = cqsm_pkg::KIND_W;
  localparam int unsigned NW = cqsm_pkg::CNT_W;

  cqsm_pkg::state_t state_r, state_nxt;
  logic                 accept;
  logic [AW-1:0]        clr_cnt_r;
  logic [TABLE_DEPTH-1:0] valid_r;
  logic [W-1:0]         next_id_r, next_fence_r;
  logic [NW-1:0]        pending_r, peak_r, lost_r;
  logic                 reset_flag_r;

  logic [W-1:0]         res_id_r, res_fnum_r, res_hash_r;
  logic                 res_fence_r, res_found_r;
  logic [1:0]           res_status_r;
  logic [KW-1:0]        ent_kind_r;
  logic [W-1:0]         ent_value_r;

  logic [cqsm_pkg::ENTRY_W-1:0] ent_wdata, ent_rdata;
  logic                 ent_we;
  logic [KW-1:0]        f_kind;
  logic [W-1:0]         f_start, f_len, f_value;
  logic [W:0]           f_end;
  logic                 f_range_bad, f_kind_bad;

  logic                 sub_in_table, sub_new, cmp_hit;
  logic [NW-1:0]        sub_pending;

  cqsm_pkg::walk_ctl_t  wctl;
  logic [AW-1:0]        waddr;
  logic                 wempty;
  logic [W-1:0]         whash, wword;

  logic                 host_we, dev_we;
  logic [AW-1:0]        host_waddr;
  logic [W-1:0]         host_wdata, host_rdata, dev_wdata, dev_rdata;
  logic                 out_load;

  assign accept = in_valid && !in_stall;
  assign in_stall = (state_r != cqsm_pkg::S_IDLE);
  assign out_load = (state_r == cqsm_pkg::S_DONE) && (!out_valid || !out_stall);

  // submit and complete lookups
  assign sub_in_table = (next_id_r < W'(TABLE_DEPTH));
  assign sub_new      = sub_in_table && !valid_r[next_id_r[TW-1:0]];
  assign sub_pending  = pending_r + NW'(sub_new);
  assign cmp_hit      = (in_target_id < W'(TABLE_DEPTH)) && valid_r[in_target_id[TW-1:0]];

  assign ent_wdata = {in_command_type, in_start_block, in_block_count, in_fill_value};
  assign {f_kind, f_start, f_len, f_value} = ent_rdata;
  assign f_end       = {1'b0, f_start} + {1'b0, f_len};
  assign f_range_bad = (f_end > (W + 1)'(STORE_WORDS));
  assign f_kind_bad  = (f_kind != cqsm_pkg::KIND_WRITE) && (f_kind != cqsm_pkg::KIND_READ)
                    && (f_kind != cqsm_pkg::KIND_VISIBLE) && (f_kind != cqsm_pkg::KIND_FENCE);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      cqsm_pkg::S_CLEAR: begin
        if (clr_cnt_r == AW'(STORE_WORDS - 1)) state_nxt = cqsm_pkg::S_IDLE;
      end
      cqsm_pkg::S_IDLE: begin
        if (accept) begin
          if (in_opcode == cqsm_pkg::OP_COMPLETE && cmp_hit && !in_force_enable) begin
            state_nxt = cqsm_pkg::S_FETCH;
          end else begin
            state_nxt = cqsm_pkg::S_DONE;
          end
        end
      end
      cqsm_pkg::S_FETCH: begin
        if (f_kind == cqsm_pkg::KIND_FENCE || f_kind_bad || f_range_bad) begin
          state_nxt = cqsm_pkg::S_DONE;
        end else if (f_kind == cqsm_pkg::KIND_WRITE) begin
          state_nxt = cqsm_pkg::S_WRITE;
        end else if (f_kind == cqsm_pkg::KIND_VISIBLE) begin
          state_nxt = cqsm_pkg::S_VRD;
        end else begin
          state_nxt = cqsm_pkg::S_RRD;
        end
      end
      cqsm_pkg::S_WRITE: begin
        if (wempty) state_nxt = cqsm_pkg::S_DONE;
      end
      cqsm_pkg::S_VRD: begin
        state_nxt = wempty ? cqsm_pkg::S_DONE : cqsm_pkg::S_VWR;
      end
      cqsm_pkg::S_VWR: state_nxt = cqsm_pkg::S_VRD;
      cqsm_pkg::S_RRD: begin
        state_nxt = wempty ? cqsm_pkg::S_DONE : cqsm_pkg::S_RACC;
      end
      cqsm_pkg::S_RACC: state_nxt = cqsm_pkg::S_RRD;
      cqsm_pkg::S_DONE: begin
        if (out_load) state_nxt = cqsm_pkg::S_IDLE;
      end
      default: state_nxt = cqsm_pkg::S_IDLE;
    endcase
  end

  // datapath controls
  always_comb begin
    wctl       = '0;
    host_we    = 1'b0;
    dev_we     = 1'b0;
    host_waddr = waddr;
    host_wdata = ent_value_r;
    dev_wdata  = host_rdata;
    ent_we     = accept && (in_opcode == cqsm_pkg::OP_SUBMIT) && sub_in_table;
    case (state_r)
      cqsm_pkg::S_CLEAR: begin
        host_we    = 1'b1;
        dev_we     = 1'b1;
        host_waddr = clr_cnt_r;
        host_wdata = '0;
        dev_wdata  = '0;
      end
      cqsm_pkg::S_FETCH: wctl.load = 1'b1;
      cqsm_pkg::S_WRITE: begin
        host_we   = !wempty;
        wctl.step = !wempty;
      end
      cqsm_pkg::S_VWR: begin
        dev_we    = 1'b1;
        wctl.step = 1'b1;
      end
      cqsm_pkg::S_RACC: begin
        wctl.acc  = 1'b1;
        wctl.step = 1'b1;
      end
      default: ;
    endcase
  end

  assign wword = dev_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= cqsm_pkg::S_CLEAR;
      clr_cnt_r    <= '0;
      valid_r      <= '0;
      next_id_r    <= '0;
      next_fence_r <= '0;
      pending_r    <= '0;
      peak_r       <= '0;
      lost_r       <= '0;
      reset_flag_r <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == cqsm_pkg::S_CLEAR) clr_cnt_r <= clr_cnt_r + AW'(1);
      if (accept) begin
        case (in_opcode)
          cqsm_pkg::OP_SUBMIT: begin
            next_id_r <= next_id_r + W'(1);
            if (in_command_type == cqsm_pkg::KIND_FENCE) next_fence_r <= next_fence_r + W'(1);
            if (sub_in_table) begin
              valid_r[next_id_r[TW-1:0]] <= 1'b1;
              pending_r <= sub_pending;
              if (sub_pending > peak_r) peak_r <= sub_pending;
            end
          end
          cqsm_pkg::OP_COMPLETE: begin
            if (cmp_hit) begin
              valid_r[in_target_id[TW-1:0]] <= 1'b0;
              pending_r <= pending_r - NW'(1);
            end
          end
          cqsm_pkg::OP_RESET: begin
            lost_r       <= pending_r;
            valid_r      <= '0;
            pending_r    <= '0;
            reset_flag_r <= 1'b1;
          end
          default: ;
        endcase
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      res_fence_r  <= 1'b0;
      res_fnum_r   <= '0;
      res_found_r  <= 1'b0;
      res_status_r <= cqsm_pkg::ST_OK;
      res_hash_r   <= '0;
      res_id_r     <= '0;
      case (in_opcode)
        cqsm_pkg::OP_SUBMIT: begin
          res_id_r <= next_id_r;
          if (in_command_type == cqsm_pkg::KIND_FENCE) begin
            res_fence_r <= 1'b1;
            res_fnum_r  <= next_fence_r;
          end
        end
        cqsm_pkg::OP_COMPLETE: begin
          res_id_r    <= in_target_id;
          res_found_r <= cmp_hit;
          if (cmp_hit && in_force_enable) begin
            res_status_r <= (in_forced_status == cqsm_pkg::ST_BAD) ? cqsm_pkg::ST_ERR
                                                                  : in_forced_status;
          end
        end
        default: ;
      endcase
    end
    if (state_r == cqsm_pkg::S_FETCH) begin
      ent_kind_r  <= f_kind;
      ent_value_r <= f_value;
      if (f_kind_bad || (f_kind != cqsm_pkg::KIND_FENCE && f_range_bad)) begin
        res_status_r <= cqsm_pkg::ST_ERR;
      end
    end
    if (state_r == cqsm_pkg::S_RRD && wempty && ent_kind_r == cqsm_pkg::KIND_READ) begin
      res_hash_r <= whash;
    end
    if (out_load) begin
      out_assigned_id       <= res_id_r;
      out_fence_flag        <= res_fence_r;
      out_fence_number      <= res_fnum_r;
      out_found             <= res_found_r;
      out_cmd_status        <= res_status_r;
      out_read_hash         <= res_hash_r;
      out_pending_total     <= pending_r;
      out_pending_high_mark <= peak_r;
      out_lost_total        <= lost_r;
      out_reset_seen        <= reset_flag_r;
    end
  end

  cqsm_ram #(.WIDTH(cqsm_pkg::ENTRY_W), .DEPTH(TABLE_DEPTH)) u_entry_ram (
    .clk   (clk),
    .we    (ent_we),
    .waddr (next_id_r[TW-1:0]),
    .wdata (ent_wdata),
    .raddr (in_target_id[TW-1:0]),
    .rdata (ent_rdata)
  );

  cqsm_ram #(.WIDTH(W), .DEPTH(STORE_WORDS)) u_host_ram (
    .clk   (clk),
    .we    (host_we),
    .waddr (host_waddr),
    .wdata (host_wdata),
    .raddr (waddr),
    .rdata (host_rdata)
  );

  cqsm_ram #(.WIDTH(W), .DEPTH(STORE_WORDS)) u_dev_ram (
    .clk   (clk),
    .we    (dev_we),
    .waddr (host_waddr),
    .wdata (dev_wdata),
    .raddr (waddr),
    .rdata (dev_rdata)
  );

  cqsm_walk #(.STORE_WORDS(STORE_WORDS)) u_walk (
    .clk        (clk),
    .ctl        (wctl),
    .load_addr  (f_start[AW-1:0]),
    .load_count (f_len[CW-1:0]),
    .word       (wword),
    .addr       (waddr),
    .empty      (wempty),
    .hash       (whash)
  );

  `CQSM_ASSERT_IMP(a_pending_matches, 1'b1, (NW'($countones(valid_r)) == pending_r), "pending count out of step with valid bits")
  `CQSM_ASSERT_IMP(a_peak_bound, 1'b1, (peak_r >= pending_r), "high mark below pending count")
  `CQSM_ASSERT_NXT(a_out_from_done, (state_r != cqsm_pkg::S_DONE) && !out_valid, !out_valid, "result appeared without a finished item")
endmodule
